[rtl/core/gls_pkg.sv]
`timescale 1ns / 1ps

package gls_pkg;

   localparam int LAYER_CNT = 2;
   localparam int IN_W      = 16;
   localparam int HID_W     = 16;
   localparam int LAY_W     = 1;
   localparam int ROW_W     = 4;
   localparam int CNT_W     = 5;
   localparam int K_W       = 5;
   localparam int ACC_W     = 40;
   localparam int Q_ONE     = 4096;

   localparam int W_DEPTH      = 3072;
   localparam int W_AW         = 12;
   localparam int W_LAYER_SPAN = 1536;
   localparam int W_GATE_SPAN  = 512;
   localparam int B_DEPTH      = 96;
   localparam int B_AW         = 7;
   localparam int B_LAYER_SPAN = 48;
   localparam int B_GATE_SPAN  = 16;
   localparam int H_DEPTH      = 32;
   localparam int H_AW         = 5;
   localparam int CP_W         = 6;

   localparam logic [LAY_W-1:0] TOP_LAYER = LAY_W'(LAYER_CNT - 1);

   localparam logic signed [ACC_W-1:0] RND_HALF = 2048;
   localparam logic signed [ACC_W-1:0] SAT_HI   = 32767;
   localparam logic signed [ACC_W-1:0] SAT_LO   = -32768;

   typedef logic signed [15:0] q_type;

   typedef enum logic [1:0] {
      CMD_LOAD_W    = 2'd0,
      CMD_LOAD_INIT = 2'd1,
      CMD_START     = 2'd2,
      CMD_ELEM      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      GATE_Z = 2'd0,
      GATE_R = 2'd1,
      GATE_C = 2'd2
   } gate_type;

   typedef enum logic [1:0] {
      KIND_IN   = 2'd0,
      KIND_HID  = 2'd1,
      KIND_BIAS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_IBUF = 2'd0,
      OP_HID  = 2'd1,
      OP_G    = 2'd2
   } op_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_BIAS,
      ST_MAC,
      ST_DRAIN,
      ST_FACT,
      ST_FMUL,
      ST_FWR,
      ST_ERD,
      ST_ELD,
      ST_EOUT
   } state_type;

   typedef struct packed {
      logic [1:0] command;
      logic       layer_index;
      logic [3:0] gate_part;
      logic [3:0] row_index;
      logic [3:0] column_index;
      q_type      value;
      logic       use_initial;
      logic       last_element;
   } req_type;

   typedef struct packed {
      q_type      hidden_value;
      logic [3:0] hidden_index;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic     ok;
      gate_type gate;
      kind_type kind;
   } part_dec_type;

   typedef struct packed {
      logic             w_we;
      logic [W_AW-1:0]  w_waddr;
      logic [W_AW-1:0]  w_raddr;
      logic             b_we;
      logic [B_AW-1:0]  b_waddr;
      logic [B_AW-1:0]  b_raddr;
      logic             i_we;
      logic [H_AW-1:0]  i_waddr;
      logic [H_AW-1:0]  i_raddr;
      q_type            wdata;
   } st_ctrl_type;

   typedef struct packed {
      logic [H_AW-1:0]  hid_raddr;
      logic             hid_we;
      logic [H_AW-1:0]  hid_waddr;
      q_type            hid_wdata;
      logic             hid_clear;
      logic             ib_we;
      logic [ROW_W-1:0] ib_waddr;
      q_type            ib_wdata;
      op_src_type       op_src;
      logic [ROW_W-1:0] op_idx;
      logic             op_zero;
      logic             z_we;
      logic             g_we;
      logic [ROW_W-1:0] zg_waddr;
      q_type            zg_wdata;
      logic [ROW_W-1:0] z_raddr;
   } vec_ctrl_type;

   typedef struct packed {
      logic     issue;
      logic     acc_load;
      logic     fin_sat;
      logic     fin_act;
      logic     fin_mul;
      gate_type gate;
   } dp_ctrl_type;

   function automatic part_dec_type part_dec(input logic [3:0] part);
      part_dec_type d;
      d = '{ok: 1'b1, gate: GATE_Z, kind: KIND_IN};
      unique case (part)
         4'd0: d = '{ok: 1'b1, gate: GATE_Z, kind: KIND_IN};
         4'd1: d = '{ok: 1'b1, gate: GATE_Z, kind: KIND_HID};
         4'd2: d = '{ok: 1'b1, gate: GATE_Z, kind: KIND_BIAS};
         4'd3: d = '{ok: 1'b1, gate: GATE_R, kind: KIND_IN};
         4'd4: d = '{ok: 1'b1, gate: GATE_R, kind: KIND_HID};
         4'd5: d = '{ok: 1'b1, gate: GATE_R, kind: KIND_BIAS};
         4'd6: d = '{ok: 1'b1, gate: GATE_C, kind: KIND_IN};
         4'd7: d = '{ok: 1'b1, gate: GATE_C, kind: KIND_HID};
         4'd8: d = '{ok: 1'b1, gate: GATE_C, kind: KIND_BIAS};
         default: d.ok = 1'b0;
      endcase
      return d;
   endfunction

   // layer, gate, kind (input / hidden), row, column
   function automatic logic [W_AW-1:0] w_addr(input logic [LAY_W-1:0] lay, input gate_type g,
                                              input logic kind, input logic [ROW_W-1:0] row,
                                              input logic [ROW_W-1:0] col);
      return W_AW'(lay) * W_AW'(W_LAYER_SPAN) + W_AW'(g) * W_AW'(W_GATE_SPAN)
             + W_AW'({kind, row, col});
   endfunction

   function automatic logic [B_AW-1:0] b_addr(input logic [LAY_W-1:0] lay, input gate_type g,
                                              input logic [ROW_W-1:0] row);
      return B_AW'(lay) * B_AW'(B_LAYER_SPAN) + B_AW'(g) * B_AW'(B_GATE_SPAN) + B_AW'(row);
   endfunction

   // round half up to Q4.12, saturate to 16 bits
   function automatic q_type rnd_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = (a + RND_HALF) >>> 12;
      if (t > SAT_HI)
         return 16'sh7fff;
      else if (t < SAT_LO)
         return 16'sh8000;
      return t[15:0];
   endfunction

   // sigmoid samples at steps of 0.5 over [0, 8]
   function automatic logic [11:0] sig_tab(input logic [4:0] idx);
      logic [11:0] v;
      unique case (idx)
         5'd0:  v = 12'd2048;
         5'd1:  v = 12'd2550;
         5'd2:  v = 12'd2994;
         5'd3:  v = 12'd3349;
         5'd4:  v = 12'd3608;
         5'd5:  v = 12'd3785;
         5'd6:  v = 12'd3902;
         5'd7:  v = 12'd3976;
         5'd8:  v = 12'd4022;
         5'd9:  v = 12'd4051;
         5'd10: v = 12'd4069;
         5'd11: v = 12'd4079;
         5'd12: v = 12'd4086;
         5'd13: v = 12'd4090;
         5'd14: v = 12'd4092;
         5'd15: v = 12'd4094;
         default: v = 12'd4095;
      endcase
      return v;
   endfunction

   function automatic logic [12:0] sig_q(input q_type x);
      logic [15:0] a;
      logic [4:0]  idx;
      logic [10:0] frac;
      logic [11:0] t0;
      logic [11:0] t1;
      logic [22:0] pr;
      logic [11:0] y;
      a    = x[15] ? 16'(-x) : 16'(x);
      idx  = a[15:11];
      frac = a[10:0];
      t0   = sig_tab(idx);
      t1   = sig_tab(5'(idx + 5'd1));
      pr   = 23'(t1 - t0) * 23'(frac);
      y    = (idx >= 5'd16) ? 12'd4095 : t0 + 12'(pr >> 11);
      return x[15] ? 13'(Q_ONE) - {1'b0, y} : {1'b0, y};
   endfunction

   // tanh(x) = 2 sig(2x) - 1
   function automatic logic signed [13:0] tanh_q(input q_type x);
      logic signed [16:0] d2;
      q_type              d;
      logic signed [14:0] t;
      d2 = {x, 1'b0};
      if (d2 > 17'sd32767)
         d = 16'sh7fff;
      else if (d2 < -17'sd32768)
         d = 16'sh8000;
      else
         d = d2[15:0];
      t = $signed({1'b0, sig_q(d), 1'b0}) - 15'sd4096;
      return t[13:0];
   endfunction

endpackage

[rtl/core/gls_store.sv]
`timescale 1ns / 1ps

// Parameter stores: weight matrices, biases, initial hidden states.
module gls_store (
   input  logic                clock,
   input  gls_pkg::st_ctrl_type ctrl,
   output gls_pkg::q_type      w_q,
   output gls_pkg::q_type      b_q,
   output gls_pkg::q_type      i_q
);
   import gls_pkg::*;

   q_type w_mem [W_DEPTH];
   q_type b_mem [B_DEPTH];
   q_type i_mem [H_DEPTH];

   q_type w_q_ff;
   q_type b_q_ff;
   q_type i_q_ff;

   always_ff @(posedge clock) begin
      if (ctrl.w_we)
         w_mem[ctrl.w_waddr] <= ctrl.wdata;
      w_q_ff <= w_mem[ctrl.w_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.b_we)
         b_mem[ctrl.b_waddr] <= ctrl.wdata;
      b_q_ff <= b_mem[ctrl.b_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.i_we)
         i_mem[ctrl.i_waddr] <= ctrl.wdata;
      i_q_ff <= i_mem[ctrl.i_raddr];
   end

   assign w_q = w_q_ff;
   assign b_q = b_q_ff;
   assign i_q = i_q_ff;

endmodule

[rtl/core/gls_vec.sv]
`timescale 1ns / 1ps

// Vector stores: hidden state (valid bits give the zero reset), input
// buffer, z and r*h scratch. Operand mux after the registered reads.
module gls_vec (
   input  logic                 clock,
   input  logic                 reset,
   input  gls_pkg::vec_ctrl_type ctrl,
   output gls_pkg::q_type       hid_rdata,
   output gls_pkg::q_type       z_rdata,
   output gls_pkg::q_type       op_data
);
   import gls_pkg::*;

   q_type hid_mem [H_DEPTH];
   q_type ib_mem  [IN_W];
   q_type z_mem   [HID_W];
   q_type g_mem   [HID_W];

   logic [H_DEPTH-1:0] hid_vld_ff;
   logic [H_DEPTH-1:0] hid_vld_in;
   q_type              hid_q_ff;
   logic               hid_v_ff;
   q_type              ib_q_ff;
   q_type              g_q_ff;
   q_type              z_q_ff;
   op_src_type         sel_ff;
   logic               zero_ff;

   always_comb begin
      hid_vld_in = hid_vld_ff;
      if (ctrl.hid_clear)
         hid_vld_in = '0;
      if (ctrl.hid_we)
         hid_vld_in[ctrl.hid_waddr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hid_vld_ff <= '0;
      end else begin
         hid_vld_ff <= hid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.hid_we)
         hid_mem[ctrl.hid_waddr] <= ctrl.hid_wdata;
      hid_q_ff <= hid_mem[ctrl.hid_raddr];
      hid_v_ff <= hid_vld_ff[ctrl.hid_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.ib_we)
         ib_mem[ctrl.ib_waddr] <= ctrl.ib_wdata;
      ib_q_ff <= ib_mem[ctrl.op_idx];
   end

   always_ff @(posedge clock) begin
      if (ctrl.z_we)
         z_mem[ctrl.zg_waddr] <= ctrl.zg_wdata;
      z_q_ff <= z_mem[ctrl.z_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.g_we)
         g_mem[ctrl.zg_waddr] <= ctrl.zg_wdata;
      g_q_ff <= g_mem[ctrl.op_idx];
   end

   always_ff @(posedge clock) begin
      sel_ff  <= ctrl.op_src;
      zero_ff <= ctrl.op_zero;
   end

   assign hid_rdata = hid_v_ff ? hid_q_ff : '0;
   assign z_rdata   = z_q_ff;

   always_comb begin
      case (sel_ff)
         OP_IBUF: op_data = zero_ff ? '0 : ib_q_ff;
         OP_HID:  op_data = hid_rdata;
         OP_G:    op_data = g_q_ff;
         default: op_data = '0;
      endcase
   end

endmodule

[rtl/core/gls_dp.sv]
`timescale 1ns / 1ps

// MAC pipeline (read -> product -> accumulate) and gate finishing math.
module gls_dp (
   input  logic                clock,
   input  logic                reset,
   input  gls_pkg::dp_ctrl_type ctrl,
   input  gls_pkg::q_type      w_data,
   input  gls_pkg::q_type      op_data,
   input  gls_pkg::q_type      b_data,
   input  gls_pkg::q_type      h_data,
   input  gls_pkg::q_type      z_data,
   output logic                busy,
   output gls_pkg::q_type      z_out,
   output gls_pkg::q_type      g_out,
   output gls_pkg::q_type      h_out
);
   import gls_pkg::*;

   logic                    rd_vld_ff;
   logic                    prod_vld_ff;
   logic signed [31:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   q_type                   s_ff;
   q_type                   act_ff;
   q_type                   hq_ff;
   q_type                   zq_ff;
   logic signed [31:0]      p1_ff;
   logic signed [31:0]      p2_ff;
   q_type                   m1;
   logic signed [ACC_W-1:0] p1_ext;
   logic signed [ACC_W-1:0] p2_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ctrl.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff)
         prod_ff <= w_data * op_data;
      if (ctrl.acc_load)
         acc_ff <= {{(ACC_W-28){b_data[15]}}, b_data, 12'b0};
      else if (prod_vld_ff)
         acc_ff <= acc_ff + {{(ACC_W-32){prod_ff[31]}}, prod_ff};
   end

   assign m1 = (ctrl.gate == GATE_R) ? act_ff : 16'sd4096 - zq_ff;

   always_ff @(posedge clock) begin
      if (ctrl.fin_sat)
         s_ff <= rnd_sat(acc_ff);
      if (ctrl.fin_act) begin
         hq_ff <= h_data;
         zq_ff <= z_data;
         if (ctrl.gate == GATE_C)
            act_ff <= 16'(tanh_q(s_ff));
         else
            act_ff <= $signed({3'b0, sig_q(s_ff)});
      end
      if (ctrl.fin_mul) begin
         p1_ff <= m1 * hq_ff;
         p2_ff <= zq_ff * act_ff;
      end
   end

   assign p1_ext = {{(ACC_W-32){p1_ff[31]}}, p1_ff};
   assign p2_ext = {{(ACC_W-32){p2_ff[31]}}, p2_ff};

   assign busy  = rd_vld_ff | prod_vld_ff;
   assign z_out = act_ff;
   assign g_out = rnd_sat(p1_ext);
   assign h_out = rnd_sat(p1_ext + p2_ext);

endmodule

[rtl/core/gru_layer_stack_step.sv]
`timescale 1ns / 1ps

// Stacked two-layer GRU step, Q4.12 fixed point.
// req channel (valid/ready): one command item per handshake. Load-weight,
// load-initial-state and plain input elements leave the block idle and give
// no result. A start item zeroes the hidden state or copies the loaded initial
// states into the hidden store, one entry a cycle. The element item flagged
// last starts the layer pass. Every gate row is one pass of the single
// multiply-accumulate unit over 32 weights, one weight memory read per cycle,
// 48 passes a layer, both layers before the first result. Then 16 result
// items follow on the rsp channel in hidden-unit order, last_result on the
// final one; each is read from the hidden store, loaded into the output
// register and handed over before the next is read. req_ready is low while
// initial states are copied or a vector is computed or emitted; a stalled
// receiver simply holds the block in emission, the result register keeps its
// item. Reset: hidden state reads as zero, input count zero, no result pending.
// Weight, bias and initial-state stores hold nothing defined until loaded.
module gru_layer_stack_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gls_pkg::rsp_type rsp_data
);
   import gls_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;     // elements taken so far
   logic [CNT_W-1:0]   n_ff, n_in;         // element count of this vector
   logic [LAY_W-1:0]   layer_ff, layer_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   gate_type           gate_ff, gate_in;
   logic [K_W-1:0]     k_ff, k_in;         // MAC column, x half then h half
   logic [CP_W-1:0]    cp_ff, cp_in;       // init copy read pointer
   logic               cpw_ff, cpw_in;
   logic [H_AW-1:0]    cpa_ff, cpa_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rspv_ff, rspv_in;

   st_ctrl_type  st;
   vec_ctrl_type vc;
   dp_ctrl_type  dc;
   part_dec_type dec;
   logic         req_take;

   q_type st_w_q, st_b_q, st_i_q;
   q_type vec_hid, vec_z, vec_op;
   logic  dp_busy;
   q_type dp_z, dp_g, dp_h;

   gls_store u_store (
      .clock (clock),
      .ctrl  (st),
      .w_q   (st_w_q),
      .b_q   (st_b_q),
      .i_q   (st_i_q)
   );

   gls_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (vc),
      .hid_rdata (vec_hid),
      .z_rdata   (vec_z),
      .op_data   (vec_op)
   );

   gls_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (dc),
      .w_data  (st_w_q),
      .op_data (vec_op),
      .b_data  (st_b_q),
      .h_data  (vec_hid),
      .z_data  (vec_z),
      .busy    (dp_busy),
      .z_out   (dp_z),
      .g_out   (dp_g),
      .h_out   (dp_h)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid & req_ready;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      layer_in = layer_ff;
      row_in   = row_ff;
      gate_in  = gate_ff;
      k_in     = k_ff;
      cp_in    = cp_ff;
      cpw_in   = 1'b0;
      cpa_in   = cpa_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff;

      dec = part_dec(req_data.gate_part);

      st         = '0;
      st.wdata   = req_data.value;
      st.i_raddr = cp_ff[H_AW-1:0];
      st.b_raddr = b_addr(layer_ff, gate_ff, row_ff);
      st.w_raddr = w_addr(layer_ff, gate_ff, k_ff[K_W-1], row_ff, k_ff[ROW_W-1:0]);

      vc           = '0;
      vc.hid_raddr = {layer_ff, row_ff};
      vc.hid_waddr = {layer_ff, row_ff};
      vc.hid_wdata = dp_h;
      vc.ib_waddr  = cnt_ff[ROW_W-1:0];
      vc.ib_wdata  = req_data.value;
      vc.op_src    = OP_IBUF;
      vc.op_idx    = k_ff[ROW_W-1:0];
      vc.zg_waddr  = row_ff;
      vc.z_raddr   = row_ff;

      dc      = '0;
      dc.gate = gate_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (cmd_type'(req_data.command))
                  CMD_LOAD_W: begin
                     if (dec.ok) begin
                        if (dec.kind == KIND_BIAS) begin
                           st.b_we    = 1'b1;
                           st.b_waddr = b_addr(req_data.layer_index, dec.gate,
                                               req_data.row_index);
                        end else begin
                           st.w_we    = 1'b1;
                           st.w_waddr = w_addr(req_data.layer_index, dec.gate,
                                               dec.kind == KIND_HID, req_data.row_index,
                                               req_data.column_index);
                        end
                     end
                  end
                  CMD_LOAD_INIT: begin
                     st.i_we    = 1'b1;
                     st.i_waddr = {req_data.layer_index, req_data.row_index};
                  end
                  CMD_START: begin
                     cnt_in = '0;
                     if (req_data.use_initial) begin
                        cp_in    = '0;
                        state_in = ST_COPY;
                     end else begin
                        vc.hid_clear = 1'b1;
                     end
                  end
                  CMD_ELEM: begin
                     if (cnt_ff < CNT_W'(IN_W)) begin
                        vc.ib_we = 1'b1;
                        cnt_in   = cnt_ff + 1'b1;
                     end
                     if (req_data.last_element) begin
                        n_in     = (cnt_ff < CNT_W'(IN_W)) ? cnt_ff + 1'b1 : cnt_ff;
                        cnt_in   = '0;
                        layer_in = '0;
                        row_in   = '0;
                        gate_in  = GATE_Z;
                        state_in = ST_BIAS;
                     end
                  end
               endcase
            end
         end

         // read init[j], then write hidden[j] from the registered read
         ST_COPY: begin
            if (cpw_ff) begin
               vc.hid_we    = 1'b1;
               vc.hid_waddr = cpa_ff;
               vc.hid_wdata = st_i_q;
            end
            if (cp_ff == CP_W'(H_DEPTH)) begin
               state_in = ST_IDLE;
            end else begin
               cpw_in = 1'b1;
               cpa_in = cp_ff[H_AW-1:0];
               cp_in  = cp_ff + 1'b1;
            end
         end

         ST_BIAS: begin
            k_in     = '0;
            state_in = ST_MAC;
         end

         ST_MAC: begin
            dc.issue    = 1'b1;
            dc.acc_load = (k_ff == '0);
            if (!k_ff[K_W-1]) begin
               if (layer_ff == '0) begin
                  vc.op_src  = OP_IBUF;
                  vc.op_zero = ({1'b0, k_ff[ROW_W-1:0]} >= n_ff);
               end else begin
                  vc.op_src    = OP_HID;
                  vc.hid_raddr = {LAY_W'(layer_ff - 1'b1), k_ff[ROW_W-1:0]};
               end
            end else if (gate_ff == GATE_C) begin
               vc.op_src = OP_G;
            end else begin
               vc.op_src    = OP_HID;
               vc.hid_raddr = {layer_ff, k_ff[ROW_W-1:0]};
            end
            if (k_ff == {K_W{1'b1}})
               state_in = ST_DRAIN;
            else
               k_in = k_ff + 1'b1;
         end

         ST_DRAIN: begin
            if (!dp_busy) begin
               dc.fin_sat = 1'b1;
               state_in   = ST_FACT;
            end
         end

         ST_FACT: begin
            dc.fin_act = 1'b1;
            state_in   = ST_FMUL;
         end

         ST_FMUL: begin
            dc.fin_mul = 1'b1;
            state_in   = ST_FWR;
         end

         ST_FWR: begin
            state_in = ST_BIAS;
            unique case (gate_ff)
               GATE_Z: begin
                  vc.z_we     = 1'b1;
                  vc.zg_wdata = dp_z;
                  gate_in     = GATE_R;
               end
               GATE_R: begin
                  vc.g_we     = 1'b1;
                  vc.zg_wdata = dp_g;
                  if (row_ff == ROW_W'(HID_W - 1)) begin
                     row_in  = '0;
                     gate_in = GATE_C;
                  end else begin
                     row_in  = row_ff + 1'b1;
                     gate_in = GATE_Z;
                  end
               end
               GATE_C: begin
                  // in place: later rows of this phase read h only at their own row
                  vc.hid_we = 1'b1;
                  if (row_ff == ROW_W'(HID_W - 1)) begin
                     row_in  = '0;
                     gate_in = GATE_Z;
                     if (layer_ff == TOP_LAYER)
                        state_in = ST_ERD;
                     else
                        layer_in = layer_ff + 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         ST_ERD: begin
            vc.hid_raddr = {TOP_LAYER, row_ff};
            state_in     = ST_ELD;
         end

         ST_ELD: begin
            rsp_in.hidden_value = vec_hid;
            rsp_in.hidden_index = row_ff;
            rsp_in.last_result  = (row_ff == ROW_W'(HID_W - 1));
            rspv_in             = 1'b1;
            state_in            = ST_EOUT;
         end

         ST_EOUT: begin
            if (rsp_ready) begin
               rspv_in = 1'b0;
               if (row_ff == ROW_W'(HID_W - 1)) begin
                  row_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_ERD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         n_ff     <= '0;
         layer_ff <= '0;
         row_ff   <= '0;
         gate_ff  <= GATE_Z;
         k_ff     <= '0;
         cp_ff    <= '0;
         cpw_ff   <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
         layer_ff <= layer_in;
         row_ff   <= row_in;
         gate_ff  <= gate_in;
         k_ff     <= k_in;
         cp_ff    <= cp_in;
         cpw_ff   <= cpw_in;
         rspv_ff  <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      cpa_ff <= cpa_in;
      rsp_ff <= rsp_in;
   end

endmodule

[tb/gru_layer_stack_step_tb.sv]
`timescale 1ns / 1ps

module gru_layer_stack_step_tb;
   import gls_pkg::*;

   localparam int N_PART       = 9;      // valid gate_part codes 0..8
   localparam int BAD_PART     = 15;     // out of range gate_part
   localparam int IDLE_LIMIT   = 40000;  // cycles without any handshake
   localparam int TAIL_CYCLES  = 100;
   localparam int QUIET_ITEMS  = 30;     // no idling once this few are left
   localparam int RAND_ITEMS   = 250;

   localparam int SIG_LUT [17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                                   4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   gru_layer_stack_step u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // shadow copy of the block's state
   q_type w_mem   [LAYER_CNT][6][HID_W][HID_W];
   q_type b_mem   [LAYER_CNT][3][HID_W];
   q_type h0_mem  [LAYER_CNT][HID_W];
   q_type h_mem   [LAYER_CNT][HID_W];
   q_type x_buf   [IN_W];
   int    x_cnt;

   req_type pending_items [$];
   rsp_type hidden_expected [$];

   logic req_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   idle_cycles = 0;
   int   mismatches = 0;
   int   items_sent = 0;
   int   vectors_out = 0;
   int   results_seen = 0;

   // round half up to Q4.12 and clamp to 16 bits
   function automatic q_type q_round(input longint a);
      longint v;
      v = (a + 2048) >>> 12;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return q_type'(v);
   endfunction

   function automatic int sigmoid_lut(input int x);
      int a, idx, frac, y;
      a = (x < 0) ? -x : x;
      idx = a >> 11;
      frac = a & 2047;
      if (idx >= 16) y = SIG_LUT[16];
      else y = SIG_LUT[idx] + (((SIG_LUT[idx+1] - SIG_LUT[idx]) * frac) >> 11);
      return (x < 0) ? Q_ONE - y : y;
   endfunction

   function automatic int tanh_lut(input int x);
      int d;
      d = 2 * x;
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      return 2 * sigmoid_lut(d) - Q_ONE;
   endfunction

   // one GRU layer; matrices: 0 Wxz 1 Whz 2 Wxr 3 Whr 4 Wxc 5 Whc
   task automatic gru_layer(input int l, input q_type x [HID_W], output q_type h [HID_W]);
      int     z [HID_W];
      q_type  g [HID_W];
      longint az, ar, ac;
      int     r, c;
      for (int i = 0; i < HID_W; i++) begin
         az = longint'(b_mem[l][GATE_Z][i]) * Q_ONE;
         ar = longint'(b_mem[l][GATE_R][i]) * Q_ONE;
         for (int k = 0; k < HID_W; k++) begin
            az += longint'(w_mem[l][0][i][k]) * x[k] + longint'(w_mem[l][1][i][k]) * h_mem[l][k];
            ar += longint'(w_mem[l][2][i][k]) * x[k] + longint'(w_mem[l][3][i][k]) * h_mem[l][k];
         end
         z[i] = sigmoid_lut(q_round(az));
         r = sigmoid_lut(q_round(ar));
         g[i] = q_round(longint'(r) * h_mem[l][i]);
      end
      for (int i = 0; i < HID_W; i++) begin
         ac = longint'(b_mem[l][GATE_C][i]) * Q_ONE;
         for (int k = 0; k < HID_W; k++)
            ac += longint'(w_mem[l][4][i][k]) * x[k] + longint'(w_mem[l][5][i][k]) * g[k];
         c = tanh_lut(q_round(ac));
         h[i] = q_round(longint'(Q_ONE - z[i]) * h_mem[l][i] + longint'(z[i]) * c);
      end
      h_mem[l] = h;
   endtask

   // apply one accepted item to the shadow state, queue the hidden vector it yields
   task automatic gru_predict(input req_type it);
      q_type   xv [HID_W];
      q_type   hv [HID_W];
      rsp_type rs;
      int      p;
      p = it.gate_part;
      case (it.command)
         CMD_LOAD_W: begin
            if (p < N_PART) begin
               if (p % 3 == KIND_BIAS) b_mem[it.layer_index][p/3][it.row_index] = it.value;
               else w_mem[it.layer_index][(p/3)*2 + p%3][it.row_index][it.column_index] = it.value;
            end
         end
         CMD_LOAD_INIT: h0_mem[it.layer_index][it.row_index] = it.value;
         CMD_START: begin
            for (int l = 0; l < LAYER_CNT; l++)
               for (int k = 0; k < HID_W; k++)
                  h_mem[l][k] = it.use_initial ? h0_mem[l][k] : q_type'(0);
            x_cnt = 0;
         end
         default: begin
            if (x_cnt < IN_W) begin
               x_buf[x_cnt] = it.value;
               x_cnt++;
            end
            if (it.last_element) begin
               // elements that never arrived count as zero
               for (int k = 0; k < HID_W; k++) xv[k] = (k < x_cnt) ? x_buf[k] : q_type'(0);
               x_cnt = 0;
               for (int l = 0; l < LAYER_CNT; l++) begin
                  gru_layer(l, xv, hv);
                  xv = hv;
               end
               for (int k = 0; k < HID_W; k++) begin
                  rs.hidden_value = hv[k];
                  rs.hidden_index = 4'(k);
                  rs.last_result  = (k == HID_W - 1);
                  hidden_expected = {hidden_expected, rs};
               end
            end
         end
      endcase
   endtask

   // stimulus helpers
   function automatic req_type noise_item(input cmd_type c);
      req_type     it;
      logic [63:0] r;
      r = {$urandom, $urandom};
      it = r[$bits(req_type)-1:0];
      it.command = c;
      return it;
   endfunction

   function automatic q_type pick_value(input bit wide);
      if (wide) return q_type'($urandom);
      return q_type'($urandom_range(0, 2048) - 1024);
   endfunction

   task automatic push_load(input int l, input int p, input int row, input int col, input q_type v);
      req_type it;
      it = noise_item(CMD_LOAD_W);
      it.layer_index = l[0];
      it.gate_part = 4'(p);
      it.row_index = 4'(row);
      it.column_index = 4'(col);
      it.value = v;
      pending_items = {pending_items, it};
   endtask

   task automatic push_init(input int l, input int row, input q_type v);
      req_type it;
      it = noise_item(CMD_LOAD_INIT);
      it.layer_index = l[0];
      it.row_index = 4'(row);
      it.value = v;
      pending_items = {pending_items, it};
   endtask

   task automatic push_start(input bit use_init);
      req_type it;
      it = noise_item(CMD_START);
      it.use_initial = use_init;
      pending_items = {pending_items, it};
   endtask

   task automatic push_elem(input q_type v, input bit last);
      req_type it;
      it = noise_item(CMD_ELEM);
      it.value = v;
      it.last_element = last;
      pending_items = {pending_items, it};
   endtask

   // driver: new item or idle at the falling edge
   always @(negedge clock) begin
      logic    nv;
      req_type nd;
      logic    quiet;
      nv = req_valid;
      nd = req_data;
      quiet = pending_items.size() < QUIET_ITEMS;
      if (!reset && (!req_valid || req_taken)) begin
         nv = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_items.size() > 0) begin
            if (!quiet && $urandom_range(0, 11) == 0) begin
               req_gap = $urandom_range(0, 13);
            end else begin
               nv = 1'b1;
               nd = pending_items.pop_front();
            end
         end
      end
      if (reset || rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         if (rsp_gap > 0) rsp_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_gap = $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
      req_valid <= nv;
      req_data  <= nd;
   end

   // monitor: predict on accepted items, check results, watch for a hang
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            gru_predict(req_data);
            items_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (hidden_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: value %0d index %0d last %0b",
                           rsp_data.hidden_value, rsp_data.hidden_index, rsp_data.last_result);
            end else begin
               want = hidden_expected.pop_front();
               if (want.last_result) vectors_out++;
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp value %0d index %0d last %0b, got %0d %0d %0b",
                              want.hidden_value, want.hidden_index, want.last_result,
                              rsp_data.hidden_value, rsp_data.hidden_index,
                              rsp_data.last_result);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int n_rand, n;
      bit wide;
      x_cnt = 0;
      for (int l = 0; l < LAYER_CNT; l++)
         for (int k = 0; k < HID_W; k++) h_mem[l][k] = '0;

      // every weight, bias and initial state written before any vector runs
      for (int l = 0; l < LAYER_CNT; l++) begin
         for (int p = 0; p < N_PART; p++)
            for (int row = 0; row < HID_W; row++)
               if (p % 3 == KIND_BIAS) push_load(l, p, row, $urandom_range(0, 15), pick_value(0));
               else for (int col = 0; col < HID_W; col++)
                  push_load(l, p, row, col, q_type'($urandom_range(0, 1024) - 512));
         for (int row = 0; row < HID_W; row++) push_init(l, row, pick_value(1));
      end

      // directed: extremes, each command, short and unstarted vectors, bad part
      push_start(1'b0);
      push_elem(16'sh7fff, 1'b0);
      push_elem(16'sh8000, 1'b1);
      push_start(1'b1);
      push_elem(16'sh0000, 1'b1);         // one element, rest zero
      push_elem(16'sh1000, 1'b1);         // no start: runs from current state
      push_load(0, BAD_PART, 3, 3, 16'sh7fff);   // ignored
      push_load(1, 6, 0, 15, 16'sh7fff);
      push_load(1, 8, 15, 0, 16'sh8000);
      push_load(0, 0, 0, 0, 16'sh8000);
      push_init(1, 15, 16'sh7fff);
      push_init(0, 0, 16'sh8000);
      push_start(1'b1);
      for (int k = 0; k < 17; k++)         // one more than the buffer holds
         push_elem(k[0] ? 16'sh7fff : 16'sh8000, k == 16);

      // random: mostly well-formed sequences, some loads and noise
      n_rand = 0;
      while (n_rand < RAND_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) != 0) begin
               push_start($urandom_range(0, 1));
               n_rand++;
            end
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : IN_W;
            wide = $urandom_range(0, 3) == 0;
            for (int k = 0; k < n; k++) push_elem(pick_value(wide), k == n - 1);
            n_rand += n;
         end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               case ($urandom_range(0, 3))
                  0: push_load($urandom_range(0, 1), $urandom_range(N_PART, BAD_PART),
                               $urandom_range(0, 15), $urandom_range(0, 15), pick_value(1));
                  1: push_init($urandom_range(0, 1), $urandom_range(0, 15), pick_value(1));
                  default: push_load($urandom_range(0, 1), $urandom_range(0, N_PART - 1),
                                     $urandom_range(0, 15), $urandom_range(0, 15),
                                     pick_value($urandom_range(0, 1)));
               endcase
            end
            n_rand += n;
         end
      end
      push_elem(pick_value(0), 1'b1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_valid) @(posedge clock);
      while (hidden_expected.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items (full weight load, loads, starts, elements) and %0d vectors,",
               items_sent, vectors_out);
      $display("%0d results checked, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && hidden_expected.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
